// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtp_pkg.sv =====
// Constants, widths and the tempering function of the Mersenne Twister generator.
`default_nettype none

package mtp_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int COUNT_W      = 11;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [31:0]        word_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Request codes carried on req_type
    localparam logic [0:0] REQ_DRAW = 1'b0;
    localparam logic [0:0] REQ_SEED = 1'b1;

    localparam word_t  TWIST_MATRIX = 32'h9908_B0DF;
    localparam word_t  TEMPER_B     = 32'h9D2C_56FF;
    localparam word_t  TEMPER_C     = 32'hEFC6_0000;
    localparam word_t  UPPER_BIT    = 32'h8000_0000;
    localparam word_t  LOWER_BITS   = 32'h7FFF_FFFF;
    localparam word_t  SEED_MULT    = 32'h0001_0DCD;
    localparam word_t  AUTO_SEED    = 32'h0000_1105;

    localparam addr_t  LAST_ADDR    = ADDR_W'(STATE_WORDS - 1);
    localparam addr_t  FAR_ADDR     = ADDR_W'(TWIST_OFFSET);
    localparam addr_t  WRAP_POINT   = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam addr_t  WRAP_BACK    = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam count_t FULL_COUNT   = COUNT_W'(STATE_WORDS - 1);
    localparam count_t UNSEEDED     = '1;

    // Output tempering with the adapted b-mask
    function automatic word_t temper(input word_t x);
        word_t y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mersenne_twister_prng.sv =====
// Top level of the adapted Mersenne Twister generator.
// A draw (req_type 0) normally reads one word of the state memory and returns it tempered:
// the word is read into the registered read port, tempered in the fetch state and
// registered onto random_word with valid. When the words are used up, or on the first
// draw after a seed, the draw first regenerates the whole state: a priming read, 624
// read-modify-write steps at one word per cycle through the dual-read state memory, one
// drain step and the output read; 623 cheap draws follow. A seed (req_type 1) fills the
// memory one word per cycle through the seed multiplier and gives no result. A draw
// before any seed fills with the default seed first. valid is high for one cycle only;
// the receiver must take it.
`default_nettype none

module mersenne_twister_prng
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [0:0]  req_type,
    input  wire  [31:0] seed_value,
    output logic        valid,
    output logic [31:0] random_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEED  = 3'd1;
    localparam logic [2:0] ST_PRIME = 3'd2;
    localparam logic [2:0] ST_TWIST = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;

    logic [2:0]              state_reg, state_next;
    mtp_pkg::addr_t          cnt_reg, cnt_next;
    mtp_pkg::count_t         draws_left_reg, draws_left_next;
    mtp_pkg::addr_t          read_index_reg, read_index_next;
    logic                    twist_pending_reg, twist_pending_next;
    mtp_pkg::word_t          seed_word_reg, seed_word_next;
    logic                    comp_valid_reg, comp_valid_next;
    mtp_pkg::addr_t          comp_idx_reg, comp_idx_next;
    mtp_pkg::word_t          cur_reg, cur_next;
    logic                    valid_reg, valid_next;
    mtp_pkg::word_t          random_word_reg, random_word_next;

    logic                    accept;
    logic                    needs_twist;
    logic                    unseeded;
    mtp_pkg::addr_t          read_idx;
    mtp_pkg::addr_t          addr_a, addr_b, waddr;
    mtp_pkg::word_t          rdata_a, rdata_b, wdata, twist_word, mix_word;
    logic                    we;

    assign accept      = start && (state_reg == ST_IDLE);
    assign unseeded    = (draws_left_reg == mtp_pkg::UNSEEDED);
    // Regenerate when the decrement would go negative
    assign needs_twist = draws_left_reg[mtp_pkg::COUNT_W-1] || (draws_left_reg == '0);
    assign read_idx    = (read_index_reg > mtp_pkg::LAST_ADDR)
                         ? read_index_reg - mtp_pkg::addr_t'(mtp_pkg::STATE_WORDS)
                         : read_index_reg;

    // Read addresses: draw word or neighbour word on port A, far word on port B
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr_a = read_idx;
            end
            ST_TWIST:
            begin
                addr_a = (cnt_reg == mtp_pkg::LAST_ADDR) ? '0 : cnt_reg + 1'b1;
                addr_b = (cnt_reg < mtp_pkg::WRAP_POINT) ? cnt_reg + mtp_pkg::FAR_ADDR
                                                         : cnt_reg - mtp_pkg::WRAP_BACK;
            end
            default:
            begin
                addr_a = '0;
            end
        endcase
    end

    // Twist step on the data read the cycle before
    assign mix_word   = (cur_reg & mtp_pkg::UPPER_BIT) | (rdata_a & mtp_pkg::LOWER_BITS);
    assign twist_word = rdata_b ^ (mix_word >> 1)
                        ^ (mix_word[0] ? mtp_pkg::TWIST_MATRIX : '0);

    // Write port: seed fill or twist write-back, never both at once
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = seed_word_reg;
        if (comp_valid_reg)
        begin
            we    = 1'b1;
            waddr = comp_idx_reg;
            wdata = twist_word;
        end
        else if (state_reg == ST_SEED)
        begin
            we = 1'b1;
        end
    end

    mtp_state_ram u_ram
    (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        draws_left_next    = draws_left_reg;
        read_index_next    = read_index_reg;
        twist_pending_next = twist_pending_reg;
        seed_word_next     = seed_word_reg;
        comp_valid_next    = (state_reg == ST_TWIST);
        comp_idx_next      = cnt_reg;
        cur_next           = cur_reg;
        valid_next         = 1'b0;
        random_word_next   = random_word_reg;

        if (comp_valid_reg || ((state_reg == ST_TWIST) && (cnt_reg == '0)))
        begin
            cur_next = rdata_a;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (req_type == mtp_pkg::REQ_SEED)
                    begin
                        seed_word_next     = seed_value | 32'd1;
                        draws_left_next    = '0;
                        twist_pending_next = 1'b0;
                        state_next         = ST_SEED;
                    end
                    else if (needs_twist)
                    begin
                        draws_left_next = mtp_pkg::FULL_COUNT;
                        read_index_next = mtp_pkg::addr_t'(1);
                        if (unseeded)
                        begin
                            seed_word_next     = mtp_pkg::AUTO_SEED | 32'd1;
                            twist_pending_next = 1'b1;
                            state_next         = ST_SEED;
                        end
                        else
                        begin
                            state_next = ST_PRIME;
                        end
                    end
                    else
                    begin
                        draws_left_next = draws_left_reg - 1'b1;
                        read_index_next = read_idx + 1'b1;
                        state_next      = ST_FETCH;
                    end
                end
            end
            ST_SEED:
            begin
                seed_word_next = seed_word_reg * mtp_pkg::SEED_MULT;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == mtp_pkg::LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = twist_pending_reg ? ST_PRIME : ST_IDLE;
                end
            end
            ST_PRIME:
            begin
                cnt_next   = '0;
                state_next = ST_TWIST;
            end
            ST_TWIST:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mtp_pkg::LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                valid_next       = 1'b1;
                random_word_next = mtp_pkg::temper(rdata_a);
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            draws_left_reg    <= mtp_pkg::UNSEEDED;
            read_index_reg    <= '0;
            twist_pending_reg <= 1'b0;
            comp_valid_reg    <= 1'b0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            draws_left_reg    <= draws_left_next;
            read_index_reg    <= read_index_next;
            twist_pending_reg <= twist_pending_next;
            comp_valid_reg    <= comp_valid_next;
            valid_reg         <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        seed_word_reg   <= seed_word_next;
        comp_idx_reg    <= comp_idx_next;
        cur_reg         <= cur_next;
        random_word_reg <= random_word_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign random_word = random_word_reg;

endmodule

`default_nettype wire

// ===== rtl/mtp_state_ram.sv =====
// State memory: 624 x 32, one write port, two registered read ports.
`default_nettype none

module mtp_state_ram
(
    input  wire                  clk,
    input  wire                  we,
    input  wire mtp_pkg::addr_t  waddr,
    input  wire mtp_pkg::word_t  wdata,
    input  wire mtp_pkg::addr_t  raddr_a,
    input  wire mtp_pkg::addr_t  raddr_b,
    output mtp_pkg::word_t       rdata_a,
    output mtp_pkg::word_t       rdata_b
);

    mtp_pkg::word_t mem [mtp_pkg::STATE_WORDS];

    // Write, and read both ports into output registers
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/mtp_checker.sv =====
// Port-level checker for the generator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mtp_checker
(
    input wire       clk,
    input wire       rst_n,
    input wire       start,
    input wire       busy,
    input wire [0:0] req_type,
    input wire       valid
);

    logic seed_beat;

    assign seed_beat = start && !busy && (req_type == mtp_pkg::REQ_SEED);

    // A start beat always makes the block busy
    `MTP_ASSERT_NEXT(a_beat_busy, clk, rst_n, start && !busy, busy, "not busy after beat")
    // No result in the cycle after a start beat
    `MTP_ASSERT_NEXT(a_beat_no_valid, clk, rst_n, start && !busy, !valid, "early result")
    // A result strobe lasts one cycle
    `MTP_ASSERT_NEXT(a_valid_pulse, clk, rst_n, valid, !valid, "valid held")
    // Results only while idle
    `MTP_ASSERT_SAME(a_valid_idle, clk, rst_n, valid, !busy, "valid while busy")
    // A seed fill keeps the block busy beyond the next cycle
    `MTP_ASSERT_NEXT(a_seed_long, clk, rst_n, seed_beat, ##1 busy, "seed fill too short")

endmodule

bind mersenne_twister_prng mtp_checker u_mtp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .valid    (valid)
);

`default_nettype wire
